// ===== hw/rtl/sit_pkg.sv =====
// Shared types, widths and helpers for the segment intersection test.
// No dependencies. Imported by the input channel interface, the top level, the checker and the testbench.
package sit_pkg;

  // Coordinate width. All other widths follow from it.
  localparam int COORD_BITS = 16;
  // Register stages from input beat to result beat.
  localparam int PIPE_DEPTH = 4;

  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [COORD_BITS:0]     diff_t;
  typedef logic signed [2*COORD_BITS+1:0] prod_t;
  typedef logic signed [2*COORD_BITS+2:0] cross_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // Sign of a cross product, with zero flagged on its own.
  typedef struct packed {
    logic neg;
    logic zero;
  } orient_t;

  // Exact difference a - b, one bit wider than a coordinate.
  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    diff_t ax;
    diff_t bx;
    ax = {a[COORD_BITS-1], a};
    bx = {b[COORD_BITS-1], b};
    return ax - bx;
  endfunction

  // r lies between p and q inclusive, in either order.
  function automatic logic in_span(input coord_t r, input coord_t p, input coord_t q);
    return ((r >= p) || (r >= q)) && ((r <= p) || (r <= q));
  endfunction

endpackage

// ===== hw/rtl/sit_if.sv =====
// Valid/ready channel interfaces for the segment intersection test.
// Depends on sit_pkg for the coordinate type.
interface sit_in_if import sit_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t a_start_x;
  coord_t a_start_y;
  coord_t a_end_x;
  coord_t a_end_y;
  coord_t b_start_x;
  coord_t b_start_y;
  coord_t b_end_x;
  coord_t b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface sit_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ===== hw/rtl/segment_intersection_test_unit.sv =====
// Top level of the segment intersection test: a four stage pipeline.
// Depends on sit_pkg and the channel interfaces in sit_if.sv.
//
// Tests whether two closed segments A and B share a point and returns one hit bit per
// input beat. A new beat is taken every cycle while the output is not stalled, and its
// result moves through stages one to four in order. A stall at the output holds stage four,
// and the stages behind it keep moving until they close up on it. in_ch.ready drops only
// while all four stages hold data and stage four still holds an untaken result.
// Stage one forms the coordinate differences and the bounding box tests, stage two the
// eight exact products, stage three the four cross products and their signs, and stage
// four combines the signs into the hit bit. The block holds no state besides the pipeline.
module segment_intersection_test_unit import sit_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  sit_in_if.sink    in_ch,
  sit_out_if.source out_ch
);

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;

  // Orientation k uses points p, q, r: (as,ae,bs), (as,ae,be), (bs,be,as), (bs,be,ae).
  pt_t p_pt [4];
  pt_t q_pt [4];
  pt_t r_pt [4];

  diff_t s1_u_nxt [4];
  diff_t s1_v_nxt [4];
  diff_t s1_w_nxt [4];
  diff_t s1_z_nxt [4];
  logic  s1_box_nxt [4];
  diff_t s1_u_r [4];
  diff_t s1_v_r [4];
  diff_t s1_w_r [4];
  diff_t s1_z_r [4];
  logic  s1_box_r [4];

  prod_t s2_uv_r [4];
  prod_t s2_wz_r [4];
  logic  s2_box_r [4];

  orient_t s3_o_nxt [4];
  orient_t s3_o_r [4];
  logic    s3_box_r [4];

  logic hit_nxt;
  logic hit_r;

  assign en4 = !v4_r || out_ch.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  assign v1_nxt = en1 ? in_ch.valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;
  assign v3_nxt = en3 ? v2_r : v3_r;
  assign v4_nxt = en4 ? v3_r : v4_r;

  always_comb begin
    p_pt[0] = '{x: in_ch.a_start_x, y: in_ch.a_start_y};
    q_pt[0] = '{x: in_ch.a_end_x,   y: in_ch.a_end_y};
    r_pt[0] = '{x: in_ch.b_start_x, y: in_ch.b_start_y};
    p_pt[1] = p_pt[0];
    q_pt[1] = q_pt[0];
    r_pt[1] = '{x: in_ch.b_end_x,   y: in_ch.b_end_y};
    p_pt[2] = r_pt[0];
    q_pt[2] = r_pt[1];
    r_pt[2] = p_pt[0];
    p_pt[3] = r_pt[0];
    q_pt[3] = r_pt[1];
    r_pt[3] = q_pt[0];
    for (int k = 0; k < 4; k++) begin
      s1_u_nxt[k]   = coord_diff(q_pt[k].y, p_pt[k].y);
      s1_v_nxt[k]   = coord_diff(r_pt[k].x, q_pt[k].x);
      s1_w_nxt[k]   = coord_diff(q_pt[k].x, p_pt[k].x);
      s1_z_nxt[k]   = coord_diff(r_pt[k].y, q_pt[k].y);
      s1_box_nxt[k] = in_span(r_pt[k].x, p_pt[k].x, q_pt[k].x) &&
                      in_span(r_pt[k].y, p_pt[k].y, q_pt[k].y);
    end
  end

  always_comb begin
    cross_t t;
    for (int k = 0; k < 4; k++) begin
      t = cross_t'(s2_uv_r[k]) - cross_t'(s2_wz_r[k]);
      s3_o_nxt[k].neg  = t[2*COORD_BITS+2];
      s3_o_nxt[k].zero = (t == '0);
    end
  end

  // A proper crossing, or a collinear endpoint inside the other segment's box.
  assign hit_nxt = ((s3_o_r[0] != s3_o_r[1]) && (s3_o_r[2] != s3_o_r[3])) ||
                   (s3_o_r[0].zero && s3_box_r[0]) ||
                   (s3_o_r[1].zero && s3_box_r[1]) ||
                   (s3_o_r[2].zero && s3_box_r[2]) ||
                   (s3_o_r[3].zero && s3_box_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (en1) begin
        s1_u_r[k]   <= s1_u_nxt[k];
        s1_v_r[k]   <= s1_v_nxt[k];
        s1_w_r[k]   <= s1_w_nxt[k];
        s1_z_r[k]   <= s1_z_nxt[k];
        s1_box_r[k] <= s1_box_nxt[k];
      end
      if (en2) begin
        s2_uv_r[k]  <= prod_t'(s1_u_r[k]) * prod_t'(s1_v_r[k]);
        s2_wz_r[k]  <= prod_t'(s1_w_r[k]) * prod_t'(s1_z_r[k]);
        s2_box_r[k] <= s1_box_r[k];
      end
      if (en3) begin
        s3_o_r[k]   <= s3_o_nxt[k];
        s3_box_r[k] <= s2_box_r[k];
      end
    end
    if (en4) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_ch.valid = v4_r;
  assign out_ch.hit   = hit_r;

endmodule

// ===== hw/rtl/sit_checker.sv =====
// Port-level checker for segment_intersection_test_unit, and the bind that attaches it.
// Depends on sit_pkg for the pipeline depth.
module sit_checker import sit_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  localparam int CNT_BITS = $clog2(PIPE_DEPTH + 2);

  logic [CNT_BITS-1:0] cnt_r;
  logic [CNT_BITS-1:0] cnt_nxt;
  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_beat && !out_beat) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit)))
    else $error("result beat changed while stalled");

  // No result beat without an item in flight.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != '0))
    else $error("result beat with no item in flight");

  // Items in flight never exceed the pipeline depth.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  // Input back-pressure only comes from a stalled result.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output is free");

endmodule

bind segment_intersection_test_unit sit_checker u_sit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit)
);

// ===== tb/segment_intersection_test_unit_tb.sv =====
// Testbench for segment_intersection_test_unit: directed and random segment pairs, random
// idling on both channels, and a scoreboard class that predicts the hit bit exactly.
// Depends on sit_pkg, the channel interfaces in sit_if.sv and the top level.
module segment_intersection_test_unit_tb;
  import sit_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    pt_t a_start;
    pt_t a_end;
    pt_t b_start;
    pt_t b_end;
  } seg_pair_t;

  class hit_scoreboard;
    bit          expected_hits[$];
    int unsigned failures;

    // Sign of the turn p -> q -> r, exact in 64 bits.
    static function int turn_sign(pt_t p, pt_t q, pt_t r);
      longint t;
      t = (longint'(q.y) - longint'(p.y)) * (longint'(r.x) - longint'(q.x))
        - (longint'(q.x) - longint'(p.x)) * (longint'(r.y) - longint'(q.y));
      if (t == 0) return 0;
      return (t > 0) ? 1 : -1;
    endfunction

    static function bit in_bounds(pt_t p, pt_t q, pt_t r);
      longint lox, hix, loy, hiy;
      lox = (p.x < q.x) ? p.x : q.x;
      hix = (p.x < q.x) ? q.x : p.x;
      loy = (p.y < q.y) ? p.y : q.y;
      hiy = (p.y < q.y) ? q.y : p.y;
      return (r.x >= lox) && (r.x <= hix) && (r.y >= loy) && (r.y <= hiy);
    endfunction

    static function bit segments_touch(seg_pair_t s);
      int o1, o2, o3, o4;
      o1 = turn_sign(s.a_start, s.a_end, s.b_start);
      o2 = turn_sign(s.a_start, s.a_end, s.b_end);
      o3 = turn_sign(s.b_start, s.b_end, s.a_start);
      o4 = turn_sign(s.b_start, s.b_end, s.a_end);
      if (o1 != o2 && o3 != o4) return 1'b1;
      // A collinear endpoint counts only inside the other segment's box.
      if (o1 == 0 && in_bounds(s.a_start, s.a_end, s.b_start)) return 1'b1;
      if (o2 == 0 && in_bounds(s.a_start, s.a_end, s.b_end)) return 1'b1;
      if (o3 == 0 && in_bounds(s.b_start, s.b_end, s.a_start)) return 1'b1;
      if (o4 == 0 && in_bounds(s.b_start, s.b_end, s.a_end)) return 1'b1;
      return 1'b0;
    endfunction

    function void note_pair(seg_pair_t s);
      expected_hits.push_back(segments_touch(s));
    endfunction

    function void check_hit(logic actual);
      bit wanted;
      if (expected_hits.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual hit=%b",
                 $time, actual);
        failures++;
      end else begin
        wanted = expected_hits.pop_front();
        if (actual !== wanted) begin
          $display("%0t: hit mismatch: expected %b, actual %b", $time, wanted, actual);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sit_in_if  in_ch ();
  sit_out_if out_ch ();

  segment_intersection_test_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hit_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int quiet_cycles  = 0;

  always #10 clk = ~clk;

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic seg_pair_t pair_of(int ax0, int ay0, int ax1, int ay1,
                                        int bx0, int by0, int bx1, int by1);
    seg_pair_t s;
    s.a_start = {coord_t'(ax0), coord_t'(ay0)};
    s.a_end   = {coord_t'(ax1), coord_t'(ay1)};
    s.b_start = {coord_t'(bx0), coord_t'(by0)};
    s.b_end   = {coord_t'(bx1), coord_t'(by1)};
    return s;
  endfunction

  // Most pairs are built to land on the collinear, touching and degenerate paths,
  // which fully random coordinates almost never reach.
  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    int pick, bx, by, dx, dy, t0, t1, t2, t3;
    pick = $urandom_range(0, 99);
    bx = spread(2000);
    by = spread(2000);
    dx = spread(5);
    dy = spread(5);
    t0 = spread(200);
    t1 = spread(200);
    t2 = spread(200);
    t3 = spread(200);
    if (pick < 20) begin
      s = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (pick < 50) begin
      s = pair_of(spread(6), spread(6), spread(6), spread(6),
                  spread(6), spread(6), spread(6), spread(6));
    end else if (pick < 75) begin
      s = pair_of(bx + t0 * dx, by + t0 * dy, bx + t1 * dx, by + t1 * dy,
                  bx + t2 * dx, by + t2 * dy, bx + t3 * dx, by + t3 * dy);
    end else if (pick < 85) begin
      // B starts on the line of A and heads off anywhere.
      s = pair_of(bx + t0 * dx, by + t0 * dy, bx + t1 * dx, by + t1 * dy,
                  bx + t2 * dx, by + t2 * dy, bx + spread(3000), by + spread(3000));
    end else if (pick < 95) begin
      s = pair_of(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                  extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
    end else begin
      if ($urandom_range(0, 1))
        t3 = t2;
      s = pair_of(bx + t0 * dx, by + t0 * dy, bx + t0 * dx, by + t0 * dy,
                  bx + t2 * dx, by + t2 * dy, bx + t3 * dx, by + t3 * dy);
    end
    if ($urandom_range(0, 1))
      s = {s.b_start, s.b_end, s.a_start, s.a_end};
    return s;
  endfunction

  task automatic put_payload(input seg_pair_t s);
    in_ch.a_start_x <= s.a_start.x;
    in_ch.a_start_y <= s.a_start.y;
    in_ch.a_end_x   <= s.a_end.x;
    in_ch.a_end_y   <= s.a_end.y;
    in_ch.b_start_x <= s.b_start.x;
    in_ch.b_start_y <= s.b_start.y;
    in_ch.b_end_x   <= s.b_end.x;
    in_ch.b_end_y   <= s.b_end.y;
  endtask

  // Valid stays high from one beat to the next unless an idle cycle is drawn.
  task automatic send_pair(input seg_pair_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    put_payload(s);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Result side: random idling, plus a long hold-off when one is requested.
  initial begin
    int held;
    held = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
      end
      if (held > 0) begin
        out_ch.ready <= 1'b0;
        held--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    seg_pair_t seen;
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        seen = {in_ch.a_start_x, in_ch.a_start_y, in_ch.a_end_x, in_ch.a_end_y,
                in_ch.b_start_x, in_ch.b_start_y, in_ch.b_end_x, in_ch.b_end_y};
        sb.note_pair(seen);
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_hit(out_ch.hit);
        quiet_cycles = 0;
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("segment_intersection_test_unit_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    put_payload('0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 60;
    send_pair(pair_of(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(pair_of(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(pair_of(0, 0, 4, 0, 5, 0, 9, 0));
    send_pair(pair_of(0, 0, 5, 5, 5, 5, 9, 9));
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 7));
    send_pair(pair_of(0, 0, 10, 0, 5, 1, 5, 7));
    send_pair(pair_of(3, 3, 3, 3, 0, 0, 6, 6));
    send_pair(pair_of(3, 4, 3, 4, 0, 0, 6, 6));
    send_pair(pair_of(7, 7, 7, 7, 0, 0, 6, 6));
    send_pair(pair_of(2, -3, 2, -3, 2, -3, 2, -3));
    send_pair(pair_of(2, -3, 2, -3, -3, 2, -3, 2));
    send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_of(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    send_pair(pair_of(-32768, 0, 32767, 0, 0, 0, 32767, 0));
    send_pair(pair_of(-32768, -32768, -1, -1, 0, 0, 32767, 32767));
    send_pair(pair_of(0, 0, 20, 0, 5, 0, 6, 0));
    send_pair(pair_of(0, 0, 2, 2, 10, 0, 0, 10));
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(-32768, -32767, 32767, 32767, -32768, -32768, 32767, 32766));
    send_pair(pair_of(0, 10, 0, -10, 0, 5, 0, 20));
    send_pair(pair_of(32767, -32768, -32768, 32767, 32767, 32767, 32767, 32767));
    repeat (300) send_pair(random_pair());

    send_idle_pct = 60;
    recv_idle_pct = 36;
    repeat (320) send_pair(random_pair());

    // The sender keeps offering beats while the result side holds off, so the
    // pipeline fills and input ready must drop.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 64;
    repeat (310) send_pair(random_pair());
    in_ch.valid <= 1'b0;

    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH + 4) @(posedge clk);
    if (sb.failures == 0)
      $display("segment_intersection_test_unit_tb: PASS");
    else
      $display("segment_intersection_test_unit_tb: FAIL");
    $finish;
  end

endmodule
